// ===== src/ght_pkg.sv =====
`default_nettype none
package ght_pkg;

    localparam int SLOTS     = 256;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int GEN_W     = 32;
    localparam int GRP_SIZE  = 16;
    localparam int NUM_GRP   = SLOTS / GRP_SIZE;
    localparam int OFF_W     = $clog2(GRP_SIZE);
    localparam int GRP_IDX_W = $clog2(NUM_GRP);

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_QUERY      = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_REG = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic             search;
        logic             take;
        logic [IDX_W-1:0] take_slot;
        logic             give;
        logic [IDX_W-1:0] give_slot;
    } t_free_ctl;

    typedef struct packed {
        logic             any_free;
        logic [IDX_W-1:0] free_slot;
        logic             idx_free;
    } t_free_stat;

endpackage
`default_nettype wire

// ===== src/ght_ram.sv =====
`default_nettype none
module ght_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/ght_free_map.sv =====
`default_nettype none
module ght_free_map (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ght_pkg::t_free_ctl        i_ctl,
    input  wire logic [ght_pkg::IDX_W-1:0] i_idx,
    output ght_pkg::t_free_stat            o_stat
);
    import ght_pkg::*;

    logic [SLOTS-1:0]     r_free;
    logic [GRP_IDX_W-1:0] r_grp;
    logic [NUM_GRP-1:0]   w_grp_any;
    logic [GRP_IDX_W-1:0] w_grp;
    logic [GRP_SIZE-1:0]  w_in_grp;
    logic [OFF_W-1:0]     w_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            if (i_ctl.take) begin
                r_free[i_ctl.take_slot] <= 1'b0;
            end
            if (i_ctl.give) begin
                r_free[i_ctl.give_slot] <= 1'b1;
            end
        end
    end

    // first level: lowest group holding a free slot
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            w_grp_any[g] = |r_free[g*GRP_SIZE +: GRP_SIZE];
        end
        w_grp = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            if (w_grp_any[g]) begin
                w_grp = GRP_IDX_W'(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.search) begin
            r_grp <= w_grp;
        end
    end

    // second level: lowest free slot inside the latched group
    always_comb begin
        w_in_grp = r_free[r_grp*GRP_SIZE +: GRP_SIZE];
        w_off    = '0;
        for (int k = GRP_SIZE - 1; k >= 0; k--) begin
            if (w_in_grp[k]) begin
                w_off = OFF_W'(k);
            end
        end
    end

    assign o_stat.any_free  = |w_grp_any;
    assign o_stat.free_slot = {r_grp, w_off};
    assign o_stat.idx_free  = r_free[i_idx];

endmodule
`default_nettype wire

// ===== src/generational_handle_table.sv =====
// flow: an accepted request goes to S_EVAL, which registers the result; a live unregister
//   goes on to S_MOVE, which registers it instead; no new request is taken before S_IDLE,
//   set by the read-then-write of the slot memories and the two-level free-slot search
// reset: free bitmap set to all free, live count and stamp counter cleared;
//   slot memories are not cleared, and their read data is only used where already written
`default_nettype none
module generational_handle_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_cmd,
    input  wire logic [ght_pkg::IDX_W-1:0] i_handle_index,
    input  wire logic [ght_pkg::GEN_W-1:0] i_handle_generation,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [1:0]                     o_status,
    output logic [ght_pkg::IDX_W-1:0]      o_new_index,
    output logic [ght_pkg::GEN_W-1:0]      o_new_generation,
    output logic                           o_is_live,
    output logic [ght_pkg::CNT_W-1:0]      o_live_count
);
    import ght_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_MOVE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [1:0]       r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [GEN_W-1:0] r_gen;
    logic [CNT_W-1:0] r_live, n_live;
    logic [GEN_W-1:0] r_stamp, n_stamp;

    logic             r_o_valid, n_o_valid;
    logic [1:0]       r_status, n_status;
    logic [IDX_W-1:0] r_new_index, n_new_index;
    logic [GEN_W-1:0] r_new_gen, n_new_gen;
    logic             r_is_live, n_is_live;
    logic [CNT_W-1:0] r_live_cnt, n_live_cnt;

    logic             w_accept;
    logic             w_out_free;
    logic             w_hit;
    logic [CNT_W-1:0] w_last;

    t_free_ctl        w_fctl;
    t_free_stat       w_fstat;

    logic             w_gen_we;
    logic [GEN_W-1:0] w_gen_rd;
    logic             w_pos_we;
    logic [IDX_W-1:0] w_pos_waddr, w_pos_wdata, w_pos_rd;
    logic             w_dense_we, w_dense_re;
    logic [IDX_W-1:0] w_dense_waddr, w_dense_wdata, w_dense_rd;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_last     = r_live - CNT_W'(1);
    assign w_hit      = !w_fstat.idx_free && (w_gen_rd == r_gen);

    ght_free_map u_free_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_fctl),
        .i_idx  (r_idx),
        .o_stat (w_fstat)
    );

    ght_ram #(.DEPTH(SLOTS), .WIDTH(GEN_W)) u_gen_ram (
        .i_clk  (i_clk),
        .i_we   (w_gen_we),
        .i_waddr(w_fstat.free_slot),
        .i_wdata(r_stamp),
        .i_re   (w_accept),
        .i_raddr(i_handle_index),
        .o_rdata(w_gen_rd)
    );

    ght_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (w_pos_we),
        .i_waddr(w_pos_waddr),
        .i_wdata(w_pos_wdata),
        .i_re   (w_accept),
        .i_raddr(i_handle_index),
        .o_rdata(w_pos_rd)
    );

    ght_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_dense_ram (
        .i_clk  (i_clk),
        .i_we   (w_dense_we),
        .i_waddr(w_dense_waddr),
        .i_wdata(w_dense_wdata),
        .i_re   (w_dense_re),
        .i_raddr(w_last[IDX_W-1:0]),
        .o_rdata(w_dense_rd)
    );

    always_comb begin
        n_state       = r_state;
        n_live        = r_live;
        n_stamp       = r_stamp;
        n_o_valid     = r_o_valid && !i_ready;
        n_status      = r_status;
        n_new_index   = r_new_index;
        n_new_gen     = r_new_gen;
        n_is_live     = r_is_live;
        n_live_cnt    = r_live_cnt;
        w_fctl        = '0;
        w_fctl.search = w_accept;
        w_fctl.take_slot = w_fstat.free_slot;
        w_fctl.give_slot = r_idx;
        w_gen_we      = 1'b0;
        w_pos_we      = 1'b0;
        w_pos_waddr   = w_fstat.free_slot;
        w_pos_wdata   = r_live[IDX_W-1:0];
        w_dense_we    = 1'b0;
        w_dense_re    = 1'b0;
        w_dense_waddr = r_live[IDX_W-1:0];
        w_dense_wdata = w_fstat.free_slot;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_cmd == CMD_UNREGISTER && w_hit && r_live != '0) begin
                    // fetch the last dense entry for the swap-remove
                    w_dense_re = 1'b1;
                    n_state    = S_MOVE;
                end else if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_o_valid   = 1'b1;
                    n_status    = ST_OK;
                    n_new_index = '0;
                    n_new_gen   = '0;
                    n_is_live   = 1'b0;
                    unique case (r_cmd)
                        CMD_REGISTER: begin
                            if (!w_fstat.any_free || r_live >= CNT_W'(SLOTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_gen_we         = 1'b1;
                                w_pos_we         = 1'b1;
                                w_dense_we       = 1'b1;
                                w_fctl.take      = 1'b1;
                                n_stamp          = r_stamp + GEN_W'(1);
                                n_live           = r_live + CNT_W'(1);
                                n_new_index      = w_fstat.free_slot;
                                n_new_gen        = r_stamp;
                            end
                        end
                        CMD_UNREGISTER: begin
                            n_status = ST_NOT_REG;
                        end
                        CMD_QUERY: begin
                            n_is_live = w_hit;
                        end
                        default: begin
                        end
                    endcase
                    n_live_cnt = n_live;
                end
            end
            S_MOVE: begin
                if (w_out_free) begin
                    // last entry fills the hole unless the hole is the last entry
                    if ({1'b0, w_pos_rd} < w_last) begin
                        w_dense_we    = 1'b1;
                        w_dense_waddr = w_pos_rd;
                        w_dense_wdata = w_dense_rd;
                        w_pos_we      = 1'b1;
                        w_pos_waddr   = w_dense_rd;
                        w_pos_wdata   = w_pos_rd;
                    end
                    w_fctl.give = 1'b1;
                    n_live      = w_last;
                    n_state     = S_IDLE;
                    n_o_valid   = 1'b1;
                    n_status    = ST_OK;
                    n_new_index = '0;
                    n_new_gen   = '0;
                    n_is_live   = 1'b0;
                    n_live_cnt  = w_last;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_stamp   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_stamp   <= n_stamp;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_idx <= i_handle_index;
            r_gen <= i_handle_generation;
        end
        r_status    <= n_status;
        r_new_index <= n_new_index;
        r_new_gen   <= n_new_gen;
        r_is_live   <= n_is_live;
        r_live_cnt  <= n_live_cnt;
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_status;
    assign o_new_index      = r_new_index;
    assign o_new_generation = r_new_gen;
    assign o_is_live        = r_is_live;
    assign o_live_count     = r_live_cnt;

endmodule
`default_nettype wire
